@@ design/vnan_pkg.sv @@
package vnan_pkg;

	localparam int COMP_W  = 16;
	localparam int SUM_W   = 24;
	localparam int COUNT_W = 8;
	localparam int SQ_W    = 2 * SUM_W - 1;
	localparam int LEN_W   = 2 * SUM_W;

	localparam int MAX_FACES = 255;
	localparam logic [COUNT_W-1:0] COUNT_CAP =
		COUNT_W'((MAX_FACES > 255) ? 255 : MAX_FACES);

	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef struct packed {
		logic signed [COMP_W-1:0] face_nx;
		logic signed [COMP_W-1:0] face_ny;
		logic signed [COMP_W-1:0] face_nz;
		logic                     on_surface;
		logic                     last_face;
	} vnan_face_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] normal_x;
		logic signed [COMP_W-1:0] normal_y;
		logic signed [COMP_W-1:0] normal_z;
		logic [COUNT_W-1:0]       surface_count;
		logic                     zero_normal;
	} vnan_norm_t;

	typedef struct packed {
		logic acc;
		logic sq;
		logic len;
		logic init;
		logic step;
		logic load;
	} vnan_cmd_t;

endpackage

@@ design/vnan_stream_if.sv @@
interface vnan_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/vnan_lane.sv @@
module vnan_lane import vnan_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  logic                 clk,
	input  vnan_cmd_t            cmd,
	input  logic [SQ_W-1:0]      sq,
	input  logic [LEN_W-1:0]     len2,
	output logic [FRAC_BITS:0]   mag
);
	// The residual must hold the scaled square of the component plus a
	// rejected trial, which can reach about 2^(2*FRAC_BITS+52) in magnitude.
	localparam int RW = 2 * FRAC_BITS + 54;

	logic [RW-1:0]        sq_ext;
	logic [RW-1:0]        len_ext;
	logic signed [RW-1:0] res_q;
	logic signed [RW-1:0] z_q;
	logic signed [RW-1:0] l_q;
	logic signed [RW-1:0] trial;
	logic                 accept;
	logic [FRAC_BITS:0]   mag_q;

	assign sq_ext  = RW'(sq);
	assign len_ext = RW'(len2);

	// res_q = sq * 4^(F+1) - (2c-1)^2 * len2, z_q = (2c-1) * len2 * 2^(k+2),
	// l_q = len2 * 4^(k+1), for the bit position k under test.
	assign trial  = res_q - z_q - l_q;
	assign accept = ~trial[RW-1];

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			res_q <= $signed((sq_ext << (2 * FRAC_BITS + 2)) - len_ext);
			z_q   <= $signed(-(len_ext << (FRAC_BITS + 2)));
			l_q   <= $signed(len_ext << (2 * FRAC_BITS + 2));
			mag_q <= '0;
		end else if (cmd.step) begin
			if (accept) begin
				res_q <= trial;
				z_q   <= (z_q + (l_q <<< 1)) >>> 1;
			end else begin
				z_q <= z_q >>> 1;
			end
			l_q   <= l_q >>> 2;
			mag_q <= {mag_q[FRAC_BITS-1:0], accept};
		end
	end

	assign mag = mag_q;
endmodule

@@ design/vnan_dp.sv @@
module vnan_dp import vnan_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  logic       clk,
	input  logic       arst_n,
	input  vnan_cmd_t  cmd,
	input  vnan_face_t face,
	output vnan_norm_t norm
);
	logic signed [SUM_W-1:0]   sum_q [3];
	logic [COUNT_W-1:0]        count_q;
	logic [COMP_W-1:0]         comp [3];
	logic signed [SUM_W:0]     wide [3];
	logic [SUM_W-1:0]          sat [3];
	logic signed [2*SUM_W-1:0] prod [3];
	logic [SQ_W-1:0]           sq_q [3];
	logic [2:0]                neg_q;
	logic [COUNT_W-1:0]        count_hold_q;
	logic [LEN_W-1:0]          len_sum;
	logic [LEN_W-1:0]          len2_q;
	logic                      zero_q;
	logic [FRAC_BITS:0]        mag [3];
	vnan_norm_t                norm_q;

	function automatic logic [COMP_W-1:0] clamp_comp(input logic [31:0] m, input logic neg);
		logic [31:0] neg_m;
		neg_m = -m;
		if (!neg)
			clamp_comp = (m > 32'd32767) ? 16'h7fff : m[COMP_W-1:0];
		else
			clamp_comp = (m > 32'd32768) ? 16'h8000 : neg_m[COMP_W-1:0];
	endfunction

	assign comp[0] = face.face_nx;
	assign comp[1] = face.face_ny;
	assign comp[2] = face.face_nz;

	for (genvar i = 0; i < 3; i++) begin : g_comp
		always_comb begin
			wide[i] = {sum_q[i][SUM_W-1], sum_q[i]}
				+ {{(SUM_W+1-COMP_W){comp[i][COMP_W-1]}}, comp[i]};
			if (wide[i][SUM_W] != wide[i][SUM_W-1])
				sat[i] = wide[i][SUM_W] ? SUM_MIN : SUM_MAX;
			else
				sat[i] = wide[i][SUM_W-1:0];
		end

		assign prod[i] = sum_q[i] * sum_q[i];

		always_ff @(posedge clk) begin
			if (cmd.sq) begin
				sq_q[i]  <= prod[i][SQ_W-1:0];
				neg_q[i] <= sum_q[i][SUM_W-1];
			end
		end

		vnan_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk  (clk),
			.cmd  (cmd),
			.sq   (sq_q[i]),
			.len2 (len2_q),
			.mag  (mag[i])
		);
	end

	// The sums clear as soon as their squares are taken, ready for the next vertex.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) sum_q[i] <= '0;
			count_q <= '0;
		end else if (cmd.sq) begin
			for (int i = 0; i < 3; i++) sum_q[i] <= '0;
			count_q <= '0;
		end else if (cmd.acc && face.on_surface) begin
			for (int i = 0; i < 3; i++) sum_q[i] <= $signed(sat[i]);
			if (count_q < COUNT_CAP)
				count_q <= count_q + 1'b1;
		end
	end

	assign len_sum = LEN_W'(sq_q[0]) + LEN_W'(sq_q[1]) + LEN_W'(sq_q[2]);

	always_ff @(posedge clk) begin
		if (cmd.sq)
			count_hold_q <= count_q;
		if (cmd.len) begin
			len2_q <= len_sum;
			zero_q <= (count_hold_q == '0) || (len_sum == '0);
		end
		if (cmd.load) begin
			norm_q.normal_x      <= zero_q ? '0 : clamp_comp(32'(mag[0]), neg_q[0]);
			norm_q.normal_y      <= zero_q ? '0 : clamp_comp(32'(mag[1]), neg_q[1]);
			norm_q.normal_z      <= zero_q ? '0 : clamp_comp(32'(mag[2]), neg_q[2]);
			norm_q.surface_count <= count_hold_q;
			norm_q.zero_normal   <= zero_q;
		end
	end

	assign norm = norm_q;
endmodule

@@ design/vnan_ctrl.sv @@
module vnan_ctrl import vnan_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      last_face,
	input  logic      out_ready,
	output logic      in_ready,
	output logic      out_valid,
	output vnan_cmd_t cmd
);
	localparam int CW = $clog2(FRAC_BITS + 1);
	localparam logic [CW-1:0] STEP_FIRST = CW'(FRAC_BITS);

	localparam logic [2:0] ST_ACC  = 3'd0;
	localparam logic [2:0] ST_SQ   = 3'd1;
	localparam logic [2:0] ST_LEN  = 3'd2;
	localparam logic [2:0] ST_INIT = 3'd3;
	localparam logic [2:0] ST_ITER = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]    state_q;
	logic [2:0]    state_d;
	logic [CW-1:0] step_q;
	logic          out_valid_q;

	assign in_ready  = (state_q == ST_ACC);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_ACC: begin
				cmd.acc = in_valid;
				if (in_valid && last_face)
					state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.sq  = 1'b1;
				state_d = ST_LEN;
			end
			ST_LEN: begin
				cmd.len = 1'b1;
				state_d = ST_INIT;
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = ST_ITER;
			end
			ST_ITER: begin
				cmd.step = 1'b1;
				if (step_q == '0)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				// The result register is free once its previous transaction completes.
				if (!out_valid_q || out_ready) begin
					cmd.load = 1'b1;
					state_d  = ST_ACC;
				end
			end
			default: state_d = ST_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.init)
				step_q <= STEP_FIRST;
			else if (cmd.step)
				step_q <= step_q - 1'b1;
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end
endmodule

@@ design/vertex_normal_accumulate_normalize_core.sv @@
// Vertex normal averaging.
// The face channel carries the face normals around one vertex, Q1.14, with a
// surface flag and a last-face mark. Surface faces are summed in saturating
// 24-bit accumulators and counted up to 255. The item with the last-face mark
// closes the vertex and one transaction appears on the vnorm channel: the sum
// scaled to unit length with FRAC_BITS fraction bits, rounded to nearest, the
// face count, and a flag when the sum was zero or no face counted.
// While summing, one face is taken every cycle. After the last face the input
// stops while the squares, the length and then one result bit per cycle for
// all three components are found in a restoring bit-serial divide-and-root
// loop, and it stays stopped until the result register takes the new normal.
// The result register holds one finished normal; the next vertex is summed
// while it waits, but the loop does not hand over a new result until the
// receiver has taken the previous one.
// Reset clears the sums, the count and the control state; no result is shown.
module vertex_normal_accumulate_normalize_core import vnan_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input logic            clk,
	input logic            arst_n,
	vnan_stream_if.sink    face,
	vnan_stream_if.source  vnorm
);
	vnan_cmd_t  cmd;
	vnan_face_t face_data;
	vnan_norm_t norm_data;

	assign face_data = face.data;

	vnan_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (face.valid),
		.last_face (face_data.last_face),
		.out_ready (vnorm.ready),
		.in_ready  (face.ready),
		.out_valid (vnorm.valid),
		.cmd       (cmd)
	);

	vnan_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.face   (face_data),
		.norm   (norm_data)
	);

	assign vnorm.data = norm_data;

`ifndef SYNTH
	vnan_norm_t chk_norm;
	assign chk_norm = vnorm.data;

	a_last_stops_input: assert property (@(posedge clk) disable iff (!arst_n)
		face.valid && face.ready && face_data.last_face |=> !face.ready)
		else $error("input still ready after the last face of a vertex");

	a_zero_vector: assert property (@(posedge clk) disable iff (!arst_n)
		vnorm.valid && chk_norm.zero_normal |->
		chk_norm.normal_x == '0 && chk_norm.normal_y == '0 && chk_norm.normal_z == '0)
		else $error("zero flag raised with a nonzero normal");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vnorm.valid && !chk_norm.zero_normal |-> chk_norm.surface_count != '0)
		else $error("normal given with no surface face counted");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		vnorm.valid |-> chk_norm.surface_count <= COUNT_CAP)
		else $error("surface count above its cap");
`endif
endmodule

@@ tb/vnan_normal_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels, keeps its own copy of the running sums and the face
// count, and predicts the unit normal that closes each vertex.
module vnan_normal_checker import vnan_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       face_valid,
	input  logic       face_ready,
	input  vnan_face_t face_data,
	input  logic       norm_valid,
	input  logic       norm_ready,
	input  vnan_norm_t norm_data,
	output int         fail_count,
	output int         pending
);

	localparam int SUM_HI = 2 ** (SUM_W - 1) - 1;
	localparam int SUM_LO = -(2 ** (SUM_W - 1));
	localparam int REPORT_LINES = 40;

	logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
	logic [COUNT_W-1:0]      faces;
	vnan_norm_t              expected_normals[$];
	vnan_norm_t              want;
	int                      errors;
	int                      normals_seen;

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W-1:0] acc,
			input logic signed [COMP_W-1:0] comp);
		int s;
		s = int'(acc) + int'(comp);
		if (s > SUM_HI)
			s = SUM_HI;
		if (s < SUM_LO)
			s = SUM_LO;
		return s[SUM_W-1:0];
	endfunction

	// Largest q with (2q-1)^2 * len2 <= (2|s|)^2 * 2^(2F), i.e. |s|*2^F/len
	// rounded to nearest with halves going away from zero.
	function automatic logic signed [COMP_W-1:0] unit_comp(input logic signed [SUM_W-1:0] s,
			input logic [127:0] len2);
		longint     sv;
		longint     q;
		logic [127:0] mag, rhs, lo, hi, mid, t;
		sv = longint'(s);
		mag = (sv < 0) ? 128'(-sv) : 128'(sv);
		rhs = (mag * mag) << (2 * FRAC_BITS + 2);
		lo = '0;
		hi = 128'(1) << FRAC_BITS;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			t = 2 * mid - 1;
			if (t * t * len2 <= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		q = longint'(lo);
		if (sv < 0)
			q = -q;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[COMP_W-1:0];
	endfunction

	function automatic vnan_norm_t predict_normal(input logic signed [SUM_W-1:0] sx, sy, sz,
			input logic [COUNT_W-1:0] count);
		vnan_norm_t   r;
		logic [127:0] len2;
		len2 = 128'(longint'(sx) * longint'(sx) + longint'(sy) * longint'(sy)
			+ longint'(sz) * longint'(sz));
		r.surface_count = count;
		r.zero_normal = (count == 0) || (len2 == 0);
		if (r.zero_normal) begin
			r.normal_x = '0;
			r.normal_y = '0;
			r.normal_z = '0;
		end else begin
			r.normal_x = unit_comp(sx, len2);
			r.normal_y = unit_comp(sy, len2);
			r.normal_z = unit_comp(sz, len2);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (errors < REPORT_LINES)
			$display("%0t ns: normal %0d: %s", $time, normals_seen, msg);
		errors++;
	endtask

	task automatic check_field(input string field, input int got, input int expected);
		if (got != expected)
			report_mismatch($sformatf("%s is %0d, expected %0d", field, got, expected));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x = '0;
			sum_y = '0;
			sum_z = '0;
			faces = '0;
			expected_normals.delete();
			errors = 0;
			normals_seen = 0;
		end else begin
			if (norm_valid && norm_ready) begin
				if (expected_normals.size() == 0) begin
					report_mismatch("transaction arrived with no vertex closed");
				end else begin
					want = expected_normals.pop_front();
					check_field("normal_x", int'(norm_data.normal_x), int'(want.normal_x));
					check_field("normal_y", int'(norm_data.normal_y), int'(want.normal_y));
					check_field("normal_z", int'(norm_data.normal_z), int'(want.normal_z));
					check_field("surface_count", int'(norm_data.surface_count),
						int'(want.surface_count));
					check_field("zero_normal", int'(norm_data.zero_normal),
						int'(want.zero_normal));
				end
				normals_seen++;
			end
			if (face_valid && face_ready) begin
				if (face_data.on_surface) begin
					sum_x = sat_sum(sum_x, face_data.face_nx);
					sum_y = sat_sum(sum_y, face_data.face_ny);
					sum_z = sat_sum(sum_z, face_data.face_nz);
					if (faces < COUNT_CAP)
						faces++;
				end
				if (face_data.last_face) begin
					expected_normals.push_back(predict_normal(sum_x, sum_y, sum_z, faces));
					sum_x = '0;
					sum_y = '0;
					sum_z = '0;
					faces = '0;
				end
			end
		end
		fail_count <= errors;
		pending <= expected_normals.size();
	end

endmodule

@@ tb/vertex_normal_accumulate_normalize_core_tb.sv @@
`timescale 1ns / 100ps

module vertex_normal_accumulate_normalize_core_tb;
	import vnan_pkg::*;

	localparam int FRAC_BITS    = 14;
	localparam int ITEM_TARGET  = 1150;
	localparam int LONG_FACES   = 270;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_PCT     = 30;
	localparam int SETTLE       = 2 * (FRAC_BITS + 5) + 10;
	localparam int CYCLE_LIMIT  = 400000;

	logic clk;
	logic arst_n;
	logic idling_on;
	logic hold_off_req;
	int   fail_count;
	int   pending;
	int   items_sent;
	int   cycle_count;

	vnan_stream_if #(.T(vnan_face_t)) face_ch ();
	vnan_stream_if #(.T(vnan_norm_t)) norm_ch ();

	vertex_normal_accumulate_normalize_core #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.face   (face_ch),
		.vnorm  (norm_ch)
	);

	vnan_normal_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.face_valid (face_ch.valid),
		.face_ready (face_ch.ready),
		.face_data  (face_ch.data),
		.norm_valid (norm_ch.valid),
		.norm_ready (norm_ch.ready),
		.norm_data  (norm_ch.data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [COMP_W-1:0] rand_comp();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: return 16'(-16384);
					1: return 16'(16384);
					2: return 16'(0);
					3: return 16'(1);
					default: return 16'(-1);
				endcase
			end
			1: return 16'($urandom);
			default: return 16'($urandom_range(32768) - 16384);
		endcase
	endfunction

	// Offers one face and returns at the edge where the transaction happens.
	task automatic send_face(input logic [COMP_W-1:0] x, y, z, input logic surf, last);
		vnan_face_t f;
		while (idling_on && $urandom_range(99) < IDLE_PCT) begin
			face_ch.valid <= 1'b0;
			@(posedge clk);
		end
		f.face_nx = x;
		f.face_ny = y;
		f.face_nz = z;
		f.on_surface = surf;
		f.last_face = last;
		face_ch.valid <= 1'b1;
		face_ch.data <= f;
		@(posedge clk);
		while (!face_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		face_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic send_random_vertex();
		int n;
		int surf_pct;
		n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		case ($urandom_range(5))
			0: surf_pct = 0;
			1: surf_pct = 50;
			default: surf_pct = 90;
		endcase
		for (int i = 0; i < n; i++)
			send_face(rand_comp(), rand_comp(), rand_comp(),
				$urandom_range(99) < surf_pct, i == n - 1);
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		norm_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				norm_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				norm_ch.ready <= !idling_on || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		int vertex_no;
		cycle_count = 0;
		items_sent = 0;
		idling_on = 1'b1;
		hold_off_req = 1'b0;
		face_ch.valid <= 1'b0;
		face_ch.data <= '0;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Axis-aligned single faces.
		send_face(16'(16384), 16'(0), 16'(0), 1'b1, 1'b1);
		send_face(16'(0), 16'(-16384), 16'(0), 1'b1, 1'b1);
		send_face(16'(0), 16'(0), 16'(16384), 1'b1, 1'b1);
		// No surface face at all.
		send_face(16'(5000), 16'(5000), 16'(5000), 1'b0, 1'b1);
		// Opposite normals cancel to the zero vector.
		send_face(16'(-16384), 16'(-16384), 16'(-16384), 1'b1, 1'b0);
		send_face(16'(16384), 16'(16384), 16'(16384), 1'b1, 1'b1);
		// Components outside the Q1.14 unit range.
		send_face(16'h7FFF, 16'h8000, 16'h0001, 1'b1, 1'b1);
		// Mixed faces, closed by a face that does not count.
		send_face(16'(1), 16'(0), 16'(0), 1'b0, 1'b0);
		send_face(16'(-1), 16'(-1), 16'(-1), 1'b1, 1'b0);
		send_face(16'(3), 16'(4), 16'(0), 1'b1, 1'b0);
		send_face(16'(16384), 16'(16384), 16'(16384), 1'b0, 1'b1);
		send_face(16'(1), 16'(1), 16'(1), 1'b1, 1'b1);
		send_face(16'(-16384), 16'(-16384), 16'(-16384), 1'b1, 1'b1);
		send_face(16'(16384), 16'(-16384), 16'(0), 1'b1, 1'b1);
		send_face(16'(-16384), 16'(0), 16'(16384), 1'b1, 1'b0);
		send_face(16'(0), 16'(0), 16'(0), 1'b0, 1'b1);
		// A counted face whose normal is zero.
		send_face(16'(0), 16'(0), 16'(0), 1'b1, 1'b1);
		wait_drained();

		// Enough extreme faces to saturate the x and y sums and the face count.
		for (int i = 0; i < LONG_FACES; i++)
			send_face(16'h7FFF, 16'h8000, rand_comp(), 1'b1, i == LONG_FACES - 1);

		vertex_no = 0;
		while (items_sent < ITEM_TARGET) begin
			vertex_no++;
			idling_on = !(vertex_no >= 60 && vertex_no < 110);
			if (vertex_no == 30)
				hold_off_req = 1'b1;
			if (vertex_no == 80)
				wait_drained();
			send_random_vertex();
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
